// ===== hdl/imaf_pkg.sv =====
// shared constants and codes for the interval moving average filter
package imaf_pkg;

    localparam int WINDOW_DEF      = 8;
    localparam int SAMPLE_BITS_DEF = 10;

    localparam int CMD_W      = 1;
    localparam int ELAPSED_W  = 16;
    localparam int THRESH_W   = 10;
    localparam int VALUE_W    = 10;
    localparam int INTERVAL_W = 16;
    localparam int ACCUM_W    = 17;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
    localparam logic [ACCUM_W-1:0]    ACCUM_MAX      = {ACCUM_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_TICK  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CHECK = 1'b1;

endpackage

// ===== hdl/imaf_in_if.sv =====
// request channel carrying one tick or check item
interface imaf_in_if #(
    parameter int SAMPLE_BITS = imaf_pkg::SAMPLE_BITS_DEF
) ();
    import imaf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [ELAPSED_W-1:0]   elapsed;
    logic [SAMPLE_BITS-1:0] sample;
    logic [THRESH_W-1:0]    threshold;

    modport source (output valid, command, elapsed, sample, threshold, input ready);
    modport sink   (input valid, command, elapsed, sample, threshold, output ready);

endinterface

// ===== hdl/imaf_out_if.sv =====
// result channel carrying the smoothed value and its flags
interface imaf_out_if ();
    import imaf_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               new_reading;
    logic               changed;

    modport source (output valid, value, new_reading, changed, input ready);
    modport sink   (input valid, value, new_reading, changed, output ready);

endinterface

// ===== hdl/interval_moving_average_filter.sv =====
// top level: interval-gated moving average with change detection
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        command, elapsed, sample, threshold
//  o_out     out  valid/ready        value, new_reading, changed
//  i_cfg_*   in   write enable only  read_interval (16 bits)
//
//  one request per cycle while no result is stalled; its result is registered and shows in the cycle after acceptance
//  the result register frees when o_out.ready is high, so a stalled result
//  only blocks input when the register is still full and not taken
//  sync active-low reset clears timing, ring position and fill state, average and ack state
//  the ring read for the next sample is prefetched into a register
module interval_moving_average_filter #(
    parameter int WINDOW      = imaf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = imaf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [imaf_pkg::INTERVAL_W-1:0]   i_cfg_wr_data,
    imaf_in_if.sink                           i_in,
    imaf_out_if.source                        o_out
);
    import imaf_pkg::*;

    localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LOG_W     = $clog2(WINDOW);
    localparam int TOTAL_W   = SAMPLE_BITS + LOG_W;
    localparam int DIV_SHIFT = TOTAL_W + LOG_W;
    localparam int PROD_W    = TOTAL_W + DIV_SHIFT + 1;
    localparam int SUM_W     = ACCUM_W + 1;
    localparam int CMP_W     = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
    localparam longint DIV_MULT = ((longint'(1) << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

    logic [INTERVAL_W-1:0]  r_interval;
    logic [ACCUM_W-1:0]     r_accum;
    logic [POS_W-1:0]       r_pos;
    logic                   r_full;
    logic                   r_rd_ok;
    logic [SAMPLE_BITS-1:0] r_ring_rd;
    logic [SAMPLE_BITS-1:0] ring [WINDOW];
    logic [TOTAL_W-1:0]     r_total;
    logic [SAMPLE_BITS-1:0] r_value;
    logic [SAMPLE_BITS-1:0] r_acked;
    logic                   r_acked_valid;
    logic                   r_out_valid;
    logic [VALUE_W-1:0]     r_out_value;
    logic                   r_out_new;
    logic                   r_out_changed;

    logic                   accept;
    logic                   is_tick;
    logic [SUM_W-1:0]       accum_sum;
    logic [ACCUM_W-1:0]     accum_sat;
    logic                   take;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [TOTAL_W-1:0]     n_total;
    logic [SAMPLE_BITS-1:0] quot;
    logic [POS_W-1:0]       pos_next;
    logic [SAMPLE_BITS-1:0] acked_cmp;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   changed;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_tick    = (i_in.command == CMD_TICK);

    // saturating time accumulator
    assign accum_sum = SUM_W'(r_accum) + SUM_W'(i_in.elapsed);
    assign accum_sat = accum_sum[ACCUM_W] ? ACCUM_MAX : accum_sum[ACCUM_W-1:0];
    assign take      = is_tick && (accum_sat >= ACCUM_W'(r_interval));

    // entries never written read as zero
    assign old_sample = r_rd_ok ? r_ring_rd : '0;

    always_comb begin
        if (WINDOW == 1) begin
            n_total = TOTAL_W'(i_in.sample);
        end else begin
            n_total = r_total - TOTAL_W'(old_sample) + TOTAL_W'(i_in.sample);
        end
    end

    assign pos_next = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;

    generate
        if ((WINDOW & (WINDOW - 1)) == 0) begin : g_shift
            assign quot = SAMPLE_BITS'(n_total >> LOG_W);
        end else begin : g_recip
            // multiply by rounded-up reciprocal, exact over the total's range
            logic [PROD_W-1:0] prod;
            assign prod = PROD_W'(n_total) * PROD_W'(DIV_MULT);
            assign quot = SAMPLE_BITS'(prod >> DIV_SHIFT);
        end
    endgenerate

    // first check compares against the current value itself
    assign acked_cmp = r_acked_valid ? r_acked : r_value;
    assign diff      = (r_value >= acked_cmp) ? r_value - acked_cmp : acked_cmp - r_value;
    assign changed   = !is_tick && (CMP_W'(diff) >= CMP_W'(i_in.threshold));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval    <= INTERVAL_RESET;
            r_accum       <= '0;
            r_pos         <= '0;
            r_full        <= 1'b0;
            r_rd_ok       <= 1'b0;
            r_total       <= '0;
            r_value       <= '0;
            r_acked_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_interval <= i_cfg_wr_data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
                if (is_tick) begin
                    r_accum <= take ? '0 : accum_sat;
                    if (take) begin
                        r_total <= n_total;
                        r_value <= quot;
                        r_pos   <= pos_next;
                        r_rd_ok <= r_full || (pos_next == '0);
                        if (pos_next == '0) begin
                            r_full <= 1'b1;
                        end
                    end
                end else begin
                    r_acked_valid <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && take) begin
            ring[r_pos] <= i_in.sample;
            r_ring_rd   <= ring[pos_next];
        end
        if (accept && !is_tick && (!r_acked_valid || changed)) begin
            r_acked <= r_value;
        end
        if (accept) begin
            r_out_value   <= VALUE_W'(take ? quot : r_value);
            r_out_new     <= take;
            r_out_changed <= changed;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.value       = r_out_value;
    assign o_out.new_reading = r_out_new;
    assign o_out.changed     = r_out_changed;

endmodule

// ===== hdl/imaf_checker.sv =====
// port-level checks for the interval moving average filter, bound to the top level
module imaf_sva (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic [imaf_pkg::CMD_W-1:0]      i_in_command,
    input logic [imaf_pkg::THRESH_W-1:0]   i_in_threshold,
    input logic                            o_out_valid,
    input logic                            o_out_ready,
    input logic [imaf_pkg::VALUE_W-1:0]    o_out_value,
    input logic                            o_out_new_reading,
    input logic                            o_out_changed
);
    import imaf_pkg::*;

    // a stalled result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_ready) |=> (o_out_valid && $stable(o_out_value)))
        else $error("stalled result changed");

    // every accepted request produces a result on the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> o_out_valid)
        else $error("accepted request gave no result");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_new_reading && o_out_changed))
        else $error("sample and change flagged together");

    // a check never samples, and a zero threshold always reports a change
    a_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_command == CMD_CHECK))
        |=> (!o_out_new_reading && (o_out_changed || ($past(i_in_threshold) != '0))))
        else $error("check result flags wrong");

endmodule

bind interval_moving_average_filter imaf_sva u_imaf_sva (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_command      (i_in.command),
    .i_in_threshold    (i_in.threshold),
    .o_out_valid       (o_out.valid),
    .o_out_ready       (o_out.ready),
    .o_out_value       (o_out.value),
    .o_out_new_reading (o_out.new_reading),
    .o_out_changed     (o_out.changed)
);
